[design/frc_pkg.sv]
package frc_pkg;

   // Geometry and field widths
   localparam int NUM_PLANES          = 6;
   localparam int COORD_BITS_DEFAULT  = 16;
   localparam int PLANE_BITS          = 64;
   localparam int NORM_BITS           = 16;
   localparam int TOL_BITS            = 15;
   localparam int FUNC_BITS           = 2;
   // Offset and tolerance are Q12.4; move them to the 18 fraction bits of a distance
   localparam int D_SHIFT             = 14;

   // Plane word layout
   localparam int NX_LSB              = 0;
   localparam int NY_LSB              = 16;
   localparam int NZ_LSB              = 32;
   localparam int D_LSB               = 48;

   // Item function codes
   localparam logic [FUNC_BITS-1:0] FUNC_POINT_ALL   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_POINT_SIDES = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_BOX_CORNER  = 2'd2;

   // Left, right, near and far planes
   localparam logic [NUM_PLANES-1:0] SIDE_PLANES = 6'b110011;
   localparam logic [NUM_PLANES-1:0] ALL_PLANES  = 6'b111111;

   // Register file port
   localparam int CSR_ADDR_BITS       = 6;
   localparam int CSR_DATA_BITS       = 64;
   localparam int REG_IDX_LSB         = 3;
   localparam int REG_IDX_BITS        = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_PLANE_LEFT   = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_PLANE_RIGHT  = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_PLANE_BOTTOM = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_PLANE_TOP    = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_PLANE_NEAR   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_PLANE_FAR    = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_TOLERANCE    = 3'd6;

   // Per-plane verdict of one item
   typedef struct packed {
      logic below;     // distance under minus the tolerance
      logic in_front;  // distance strictly positive
   } plane_flags_type;

endpackage

[design/frc_plane_unit.sv]
module frc_plane_unit #(
   parameter int COORD_BITS = frc_pkg::COORD_BITS_DEFAULT
) (
   input  logic [frc_pkg::PLANE_BITS-1:0]     plane,
   input  logic [frc_pkg::TOL_BITS-1:0]       tolerance,
   input  logic signed [COORD_BITS-1:0]       px,
   input  logic signed [COORD_BITS-1:0]       py,
   input  logic signed [COORD_BITS-1:0]       pz,
   output frc_pkg::plane_flags_type           flags
);

   localparam int PROD_BITS = frc_pkg::NORM_BITS + COORD_BITS;
   localparam int DIST_BITS = PROD_BITS + 2;

   logic signed [frc_pkg::NORM_BITS-1:0] nx;
   logic signed [frc_pkg::NORM_BITS-1:0] ny;
   logic signed [frc_pkg::NORM_BITS-1:0] nz;
   logic signed [frc_pkg::NORM_BITS-1:0] offset;

   logic signed [PROD_BITS-1:0] prod_x, prod_y, prod_z;

   logic signed [DIST_BITS-1:0] offset_ext;
   logic signed [DIST_BITS-1:0] tol_ext;
   logic signed [DIST_BITS-1:0] limit;
   logic signed [DIST_BITS-1:0] dist_sum;

   // Unpack the plane word
   assign nx     = plane[frc_pkg::NX_LSB +: frc_pkg::NORM_BITS];
   assign ny     = plane[frc_pkg::NY_LSB +: frc_pkg::NORM_BITS];
   assign nz     = plane[frc_pkg::NZ_LSB +: frc_pkg::NORM_BITS];
   assign offset = plane[frc_pkg::D_LSB +: frc_pkg::NORM_BITS];

   // Three exact products
   assign prod_x = nx * px;
   assign prod_y = ny * py;
   assign prod_z = nz * pz;

   // Sum with scaled offset, compare against the two thresholds
   assign offset_ext = DIST_BITS'(offset);
   assign tol_ext    = DIST_BITS'(tolerance);
   assign limit      = -(tol_ext <<< frc_pkg::D_SHIFT);
   assign dist_sum   = DIST_BITS'(prod_x) + DIST_BITS'(prod_y) + DIST_BITS'(prod_z)
                       + (offset_ext <<< frc_pkg::D_SHIFT);

   assign flags.below    = dist_sum < limit;
   assign flags.in_front = !dist_sum[DIST_BITS-1] && (|dist_sum);

endmodule

[design/frustum_cull_test.sv]
// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+-----------
// request   | req_valid req_ready req_func req_px/py/pz     | in
//           | req_last_corner                              |
// response  | rsp_valid rsp_ready rsp_visible              | out
// csr       | csr_psel csr_penable csr_pwrite csr_paddr    | in/out
//           | csr_pwdata csr_prdata csr_pready             |
//
// One item per cycle sustained while results are taken. An item passes two
// registers: the input register, then the six plane units and the verdict logic
// in one pass, then the response register, which holds its result.
// Reset clears the valid flags, the plane and tolerance registers and the box
// mask. The input register stalls only when it holds an item with a result
// while the response waits; items that give no result (box corners before the
// last one, the unused code) drain even while the response waits.
module frustum_cull_test #(
   parameter int COORD_BITS = frc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [frc_pkg::FUNC_BITS-1:0]        req_func,
   input  logic signed [COORD_BITS-1:0]         req_px,
   input  logic signed [COORD_BITS-1:0]         req_py,
   input  logic signed [COORD_BITS-1:0]         req_pz,
   input  logic                                 req_last_corner,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_visible,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [frc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [frc_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [frc_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   // ---------------- configuration registers ----------------
   logic [frc_pkg::PLANE_BITS-1:0] plane_ff [frc_pkg::NUM_PLANES];
   logic [frc_pkg::TOL_BITS-1:0]   tol_ff;
   logic                           csr_write;
   logic [frc_pkg::REG_IDX_BITS-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[frc_pkg::REG_IDX_LSB +: frc_pkg::REG_IDX_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < frc_pkg::NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
         tol_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            frc_pkg::REG_PLANE_LEFT:   plane_ff[0] <= csr_pwdata;
            frc_pkg::REG_PLANE_RIGHT:  plane_ff[1] <= csr_pwdata;
            frc_pkg::REG_PLANE_BOTTOM: plane_ff[2] <= csr_pwdata;
            frc_pkg::REG_PLANE_TOP:    plane_ff[3] <= csr_pwdata;
            frc_pkg::REG_PLANE_NEAR:   plane_ff[4] <= csr_pwdata;
            frc_pkg::REG_PLANE_FAR:    plane_ff[5] <= csr_pwdata;
            frc_pkg::REG_TOLERANCE:    tol_ff <= csr_pwdata[frc_pkg::TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (reg_idx)
         frc_pkg::REG_PLANE_LEFT:   csr_prdata = plane_ff[0];
         frc_pkg::REG_PLANE_RIGHT:  csr_prdata = plane_ff[1];
         frc_pkg::REG_PLANE_BOTTOM: csr_prdata = plane_ff[2];
         frc_pkg::REG_PLANE_TOP:    csr_prdata = plane_ff[3];
         frc_pkg::REG_PLANE_NEAR:   csr_prdata = plane_ff[4];
         frc_pkg::REG_PLANE_FAR:    csr_prdata = plane_ff[5];
         frc_pkg::REG_TOLERANCE:    csr_prdata = frc_pkg::CSR_DATA_BITS'(tol_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic                          s1_valid_ff;
   logic [frc_pkg::FUNC_BITS-1:0] s1_func_ff;
   logic signed [COORD_BITS-1:0]  s1_px_ff, s1_py_ff, s1_pz_ff;
   logic                          s1_last_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_visible_ff;
   logic                          rsp_visible_in;

   logic [frc_pkg::NUM_PLANES-1:0] box_mask_ff;
   logic [frc_pkg::NUM_PLANES-1:0] box_mask_in;

   logic out_ready, s1_has_result, s1_adv;
   logic req_take;

   assign out_ready     = !rsp_valid_ff || rsp_ready;
   assign s1_has_result = (s1_func_ff == frc_pkg::FUNC_POINT_ALL)
                       || (s1_func_ff == frc_pkg::FUNC_POINT_SIDES)
                       || ((s1_func_ff == frc_pkg::FUNC_BOX_CORNER) && s1_last_ff);
   assign s1_adv        = s1_valid_ff && (out_ready || !s1_has_result);
   assign req_ready     = !s1_valid_ff || s1_adv;
   assign req_take      = req_valid && req_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff <= req_func;
         s1_px_ff   <= req_px;
         s1_py_ff   <= req_py;
         s1_pz_ff   <= req_pz;
         s1_last_ff <= req_last_corner;
      end
   end

   // ---------------- six plane units ----------------
   frc_pkg::plane_flags_type      flags [frc_pkg::NUM_PLANES];
   logic [frc_pkg::NUM_PLANES-1:0] below_vec;
   logic [frc_pkg::NUM_PLANES-1:0] in_front_vec;

   for (genvar g = 0; g < frc_pkg::NUM_PLANES; g++) begin : g_plane
      frc_plane_unit #(
         .COORD_BITS (COORD_BITS)
      ) u_plane (
         .plane     (plane_ff[g]),
         .tolerance (tol_ff),
         .px        (s1_px_ff),
         .py        (s1_py_ff),
         .pz        (s1_pz_ff),
         .flags     (flags[g])
      );
      assign below_vec[g]    = flags[g].below;
      assign in_front_vec[g] = flags[g].in_front;
   end

   // ---------------- verdict and box mask ----------------
   always_comb begin
      box_mask_in    = box_mask_ff;
      rsp_visible_in = 1'b0;
      unique case (s1_func_ff)
         frc_pkg::FUNC_POINT_ALL: begin
            rsp_visible_in = !(|(below_vec & frc_pkg::ALL_PLANES));
         end
         frc_pkg::FUNC_POINT_SIDES: begin
            rsp_visible_in = !(|(below_vec & frc_pkg::SIDE_PLANES));
         end
         frc_pkg::FUNC_BOX_CORNER: begin
            box_mask_in    = box_mask_ff | in_front_vec;
            rsp_visible_in = &box_mask_in;
            if (s1_last_ff) begin
               box_mask_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_mask_ff <= '0;
      end else if (s1_adv) begin
         box_mask_ff <= box_mask_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_has_result) begin
         rsp_visible_ff <= rsp_visible_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

[verif/frustum_cull_test_tb.sv]
module frustum_cull_test_tb;
   import frc_pkg::*;

   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam shortint UNIT = 16384;        // 1.0 in Q2.14
   localparam int SETTLE_CYCLES = 8;        // pipeline is two stages deep
   localparam int ITEMS_PER_PHASE = 120;

   // Visibility predictor and result store
   class cull_scoreboard;
      logic [PLANE_BITS-1:0] planes [NUM_PLANES];
      logic [TOL_BITS-1:0]   tol;
      logic [NUM_PLANES-1:0] box_mask;
      bit visibility_q [$];
      int errors, checked;
      int shown_points, culled_points, shown_boxes, culled_boxes;

      function new();
         foreach (planes[i]) planes[i] = '0;
         tol = '0;
         box_mask = '0;
      endfunction

      function void set_reg(logic [REG_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
         if (idx == REG_TOLERANCE)
            tol = value[TOL_BITS-1:0];
         else if (idx < REG_TOLERANCE)
            planes[idx] = value;
      endfunction

      // Exact signed distance with 18 fraction bits
      function longint distance(int i, shortint x, shortint y, shortint z);
         shortint nx, ny, nz, d;
         nx = planes[i][NX_LSB +: NORM_BITS];
         ny = planes[i][NY_LSB +: NORM_BITS];
         nz = planes[i][NZ_LSB +: NORM_BITS];
         d  = planes[i][D_LSB +: NORM_BITS];
         return longint'(nx) * x + longint'(ny) * y + longint'(nz) * z
                + (longint'(d) <<< D_SHIFT);
      endfunction

      function int pending();
         return visibility_q.size();
      endfunction

      // Accepted input item: update box mask, queue any verdict
      function void note_item(logic [FUNC_BITS-1:0] f, shortint x, shortint y, shortint z,
                              bit last);
         bit vis;
         longint floor_dist;
         vis = 1'b1;
         floor_dist = -(longint'(tol) <<< D_SHIFT);
         case (f)
            FUNC_POINT_ALL, FUNC_POINT_SIDES: begin
               for (int i = 0; i < NUM_PLANES; i++)
                  if ((f == FUNC_POINT_ALL || SIDE_PLANES[i]) && distance(i, x, y, z) < floor_dist)
                     vis = 1'b0;
               visibility_q.push_back(vis);
               if (vis) shown_points++; else culled_points++;
            end
            FUNC_BOX_CORNER: begin
               for (int i = 0; i < NUM_PLANES; i++)
                  if (distance(i, x, y, z) > 0)
                     box_mask[i] = 1'b1;
               if (last) begin
                  vis = (box_mask == ALL_PLANES);
                  visibility_q.push_back(vis);
                  if (vis) shown_boxes++; else culled_boxes++;
                  box_mask = '0;
               end
            end
            default: ;   // unused code: ignored
         endcase
      endfunction

      function void check_result(logic vis);
         bit want;
         checked++;
         if (visibility_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("frustum_cull_test_tb: result %0d arrived with none pending, visible=%b",
                        checked, vis);
         end else begin
            want = visibility_q.pop_front();
            if (vis !== want) begin
               errors++;
               if (errors <= 10)
                  $display("frustum_cull_test_tb: result %0d visible expected %0b got %b",
                           checked, want, vis);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [FUNC_BITS-1:0]    req_func = FUNC_POINT_ALL;
   logic signed [15:0]      req_px = '0;
   logic signed [15:0]      req_py = '0;
   logic signed [15:0]      req_pz = '0;
   logic                    req_last_corner = 1'b0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_visible;

   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                    csr_pready;

   cull_scoreboard sb = new();
   bit steady = 1'b0;
   int accepted_items = 0;
   int phase_count = 0;

   frustum_cull_test dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_px          (req_px),
      .req_py          (req_py),
      .req_pz          (req_pz),
      .req_last_corner (req_last_corner),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_visible     (rsp_visible),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #6 clock = ~clock;

   // Run limit
   initial begin
      #3000000;
      $display("frustum_cull_test_tb: done, errors");
      $finish;
   end

   // Result side: random stalls except in the steady phase
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_visible);
   end

   function automatic shortint sat_coord(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return shortint'(v);
   endfunction

   // Mostly around the frustum, now and then anywhere
   function automatic shortint near_coord(int span);
      if ($urandom_range(7) == 0) return shortint'($urandom());
      return sat_coord(int'($urandom_range(0, 3 * span)) - (3 * span) / 2);
   endfunction

   function automatic logic [PLANE_BITS-1:0] pack_plane(shortint nx, shortint ny, shortint nz,
                                                        shortint d);
      return {d, nz, ny, nx};
   endfunction

   // Axis-aligned cube of half width w, normals pointing inward
   function automatic logic [PLANE_BITS-1:0] axis_plane(int k, shortint w);
      case (k)
         REG_PLANE_LEFT:   return pack_plane(UNIT, 0, 0, w);
         REG_PLANE_RIGHT:  return pack_plane(-UNIT, 0, 0, w);
         REG_PLANE_BOTTOM: return pack_plane(0, UNIT, 0, w);
         REG_PLANE_TOP:    return pack_plane(0, -UNIT, 0, w);
         REG_PLANE_NEAR:   return pack_plane(0, 0, UNIT, w);
         default:          return pack_plane(0, 0, -UNIT, w);
      endcase
   endfunction

   function automatic shortint rand_norm();
      return shortint'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
   endfunction

   task automatic send_item(logic [FUNC_BITS-1:0] f, shortint x, shortint y, shortint z,
                            bit last);
      if (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_px          <= x;
      req_py          <= y;
      req_pz          <= z;
      req_last_corner <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(f, x, y, z, last);
      if (f != FUNC_UNUSED) accepted_items++;
   endtask

   // Hold the sender until every verdict is in and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, {REG_IDX_LSB{1'b0}}});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic load_planes(logic [PLANE_BITS-1:0] p [NUM_PLANES], logic [TOL_BITS-1:0] t);
      drain();
      for (int k = 0; k < NUM_PLANES; k++)
         write_reg(REG_PLANE_LEFT + REG_IDX_BITS'(k), p[k]);
      write_reg(REG_TOLERANCE, CSR_DATA_BITS'(t));
      phase_count++;
   endtask

   task automatic send_point(int span);
      send_item($urandom_range(1) ? FUNC_POINT_ALL : FUNC_POINT_SIDES,
                near_coord(span), near_coord(span), near_coord(span), $urandom_range(1));
   endtask

   // Corners of a box around a random center, now and then a point in between
   task automatic send_box(int span, int corners);
      int cx, cy, cz, h;
      cx = near_coord(span);
      cy = near_coord(span);
      cz = near_coord(span);
      h = $urandom_range(1, span / 2 + 1);
      for (int k = 0; k < corners; k++) begin
         if ($urandom_range(9) == 0) send_point(span);
         send_item(FUNC_BOX_CORNER, sat_coord(cx + (k[0] ? h : -h)),
                   sat_coord(cy + (k[1] ? h : -h)), sat_coord(cz + (k[2] ? h : -h)),
                   k == corners - 1);
      end
   endtask

   task automatic run_random(int count, int span);
      int goal, pick;
      goal = accepted_items + count;
      while (accepted_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 60)
            send_box(span, ($urandom_range(4) == 0) ? $urandom_range(1, 8) : 8);
         else if (pick < 90)
            send_point(span);
         else
            send_item(FUNC_BITS'($urandom_range(3)), shortint'($urandom()),
                      shortint'($urandom()), shortint'($urandom()), $urandom_range(1));
      end
   endtask

   initial begin
      logic [PLANE_BITS-1:0] pl [NUM_PLANES];
      logic [TOL_BITS-1:0] tl;
      int span;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset planes: every distance is zero
      send_item(FUNC_POINT_ALL, 0, 0, 0, 1'b0);
      send_item(FUNC_POINT_SIDES, -32768, 32767, -32768, 1'b1);
      send_item(FUNC_BOX_CORNER, 32767, 32767, 32767, 1'b1);
      send_item(FUNC_UNUSED, -1, -1, -1, 1'b1);

      // Cube of half width 100.0, no margin: faces and just outside
      for (int k = 0; k < NUM_PLANES; k++) pl[k] = axis_plane(k, 1600);
      load_planes(pl, '0);
      send_item(FUNC_POINT_ALL, 0, 0, 0, 1'b0);
      send_item(FUNC_POINT_ALL, -1600, 0, 0, 1'b0);
      send_item(FUNC_POINT_ALL, -1601, 0, 0, 1'b0);
      send_item(FUNC_POINT_SIDES, 0, 5000, 0, 1'b0);
      send_item(FUNC_POINT_ALL, 0, 5000, 0, 1'b0);
      send_item(FUNC_POINT_SIDES, 0, 0, -1601, 1'b0);
      // box inside, with an ignored item carrying last in the middle
      for (int k = 0; k < 8; k++) begin
         if (k == 3) send_item(FUNC_UNUSED, 0, 0, 0, 1'b1);
         send_item(FUNC_BOX_CORNER, k[0] ? 100 : -100, k[1] ? 100 : -100,
                   k[2] ? 100 : -100, k == 7);
      end
      // box lying on the left face: left plane never strictly inside
      send_item(FUNC_BOX_CORNER, -1600, 0, 0, 1'b0);
      send_item(FUNC_BOX_CORNER, -1600, 100, 100, 1'b1);

      // Widest margin with far corners
      load_planes(pl, '1);
      send_item(FUNC_POINT_ALL, -32768, -32768, -32768, 1'b0);
      send_item(FUNC_POINT_SIDES, 32767, 32767, 32767, 1'b0);

      // Random phases, each with its own register setting
      for (int p = 0; p < 7; p++) begin
         span = $urandom_range(64, 4000);
         tl = TOL_BITS'($urandom_range(0, span / 8));
         case (p)
            1: begin
               for (int k = 0; k < NUM_PLANES; k++) pl[k] = '1;
               tl = '1;
               span = 8000;
            end
            2: begin
               for (int k = 0; k < NUM_PLANES; k++)
                  pl[k] = pack_plane(rand_norm(), rand_norm(), rand_norm(),
                                     shortint'(int'($urandom_range(0, 2 * span)) - span));
            end
            3: begin
               for (int k = 0; k < NUM_PLANES; k++) pl[k] = axis_plane(k, shortint'(span));
               tl = '0;
            end
            4: begin
               // some planes have no normal at all
               for (int k = 0; k < NUM_PLANES; k++)
                  pl[k] = (k == REG_PLANE_TOP || $urandom_range(2) == 0)
                        ? pack_plane(0, 0, 0, shortint'(int'($urandom_range(0, 200)) - 50))
                        : axis_plane(k, shortint'(span));
            end
            5: begin
               for (int k = 0; k < NUM_PLANES; k++) pl[k] = 64'h8000_8000_8000_8000;
               tl = '0;
               span = 8000;
            end
            default: begin
               for (int k = 0; k < NUM_PLANES; k++) pl[k] = axis_plane(k, shortint'(span));
               if (p == 6) tl = TOL_BITS'($urandom_range(0, 32767));
            end
         endcase
         load_planes(pl, tl);
         steady = (p == 3);
         run_random(ITEMS_PER_PHASE, span);
      end
      steady = 1'b0;

      drain();
      $display("frustum_cull_test_tb: %0d items over %0d register settings, %0d verdicts checked",
               accepted_items, phase_count, sb.checked);
      $display("frustum_cull_test_tb: points %0d shown %0d culled, boxes %0d shown %0d culled",
               sb.shown_points, sb.culled_points, sb.shown_boxes, sb.culled_boxes);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("frustum_cull_test_tb: done, clean");
      else
         $display("frustum_cull_test_tb: done, errors");
      $finish;
   end

endmodule
